FILE: rtl/core/bal_pkg.sv
package bal_pkg;

    // Sizes of the table and of the growth cap
    localparam int MAX_REGIONS   = 64;
    localparam int MAX_DOUBLINGS = 16;

    localparam int IDX_W   = $clog2(MAX_REGIONS);
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int DBL_W   = 5;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 41;
    localparam int OFF_W   = 57;
    localparam int END_W   = OFF_W + 1;
    localparam int ALN_W   = OFF_W + 2;
    localparam int LOG_W   = 5;
    localparam int STAT_W  = 2;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_RESERVE = 2'd1;
    localparam logic [1:0] REG_ALIGN   = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_RST    = '0;
    localparam logic [SIZE_W-1:0] RESERVE_RST = SIZE_W'(64'd1073741824);
    localparam logic [LOG_W-1:0]  ALIGN_RST   = LOG_W'(21);

    // Item actions
    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CAP  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_COMMIT,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] length;
    } entry_t;

endpackage

FILE: rtl/core/bump_allocator_with_range_lookup.sv
// Bump allocator over a shared region, with a table of the regions handed out.
// Input channel (in_valid/in_ready): one beat is an allocate (action 0, request_size)
// or a lookup (action 1, query_address). Output channel (out_valid/out_ready): one
// result beat per input beat, in order. The user writes configuration through the
// APB port only while the block is idle; the block itself does not enforce this.
// Reads return the register values. One item at a time: an allocate goes from
// accept through the doubling loop, which doubles the reserve once per cycle, to
// the commit and result states. A lookup reads the region table memory one entry
// per cycle and each entry passes through a read stage and an add stage before
// the compare; the scan stops at the first containing region. A table-full
// allocate goes from accept straight to the result state.
// The finished result sits in an output register; the next beat is accepted while
// it waits. If the receiver stalls, a second result holds in the block until the
// output register frees, and no further beat is taken.
// Reset clears the head offset, the doubling count and the entry count and loads
// the register defaults; the table memory is not cleared, since only entries below
// the entry count are ever read.
module bump_allocator_with_range_lookup
    import bal_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [SIZE_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]    query_address,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STAT_W-1:0]    status,
    output logic [OFF_W-1:0]     alloc_address,
    output logic [OFF_W-1:0]     found_base,
    output logic [SIZE_W-1:0]    found_length,
    output logic [DBL_W-1:0]     grow_steps,
    output logic [OFF_W-1:0]     reserve_size
);

    // Configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  reserve_reg;
    logic [LOG_W-1:0]   align_reg;

    // Control state
    state_t             state_reg, state_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [DBL_W-1:0]   dcount_reg, dcount_next;
    logic [CNT_W-1:0]   ecount_reg, ecount_next;
    logic [DBL_W-1:0]   d_reg, d_next;
    logic [DBL_W-1:0]   steps_reg, steps_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic               out_valid_reg, out_valid_next;

    // Payload
    logic [END_W-1:0]   end_reg, end_next;
    logic [OFF_W-1:0]   r_reg, r_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0]  query_reg, query_next;
    logic [END_W-1:0]   b2_reg, b2_next;
    logic [SIZE_W-1:0]  l2_reg, l2_next;
    entry_t             rd_reg;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [OFF_W-1:0]   res_addr_reg, res_addr_next;
    logic [OFF_W-1:0]   res_base_reg, res_base_next;
    logic [SIZE_W-1:0]  res_len_reg, res_len_next;
    logic [DBL_W-1:0]   res_steps_reg, res_steps_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [OFF_W-1:0]   out_addr_reg, out_addr_next;
    logic [OFF_W-1:0]   out_base_reg, out_base_next;
    logic [SIZE_W-1:0]  out_len_reg, out_len_next;
    logic [DBL_W-1:0]   out_steps_reg, out_steps_next;
    logic [OFF_W-1:0]   out_reserve_reg, out_reserve_next;

    // Region table
    entry_t             table_mem [MAX_REGIONS];
    logic               mem_we;
    entry_t             mem_wdata;

    // Shared conditions
    logic               accept;
    logic               cfg_we;
    logic               table_full;
    logic               grow_need;
    logic               grow_room;
    logic               issue;
    logic               hit;
    logic               scan_empty;
    logic               slot_free;
    logic [ALN_W-1:0]   align_mask;
    logic [ALN_W-1:0]   aligned;

    assign pready     = 1'b1;
    assign cfg_we     = psel && penable && pwrite;
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;

    assign table_full = (ecount_reg >= CNT_W'(MAX_REGIONS));
    assign grow_need  = (end_reg >= {1'b0, r_reg});
    assign grow_room  = (d_reg < DBL_W'(MAX_DOUBLINGS));

    // Scan pipeline: issue read, registered data, base add, compare
    assign issue      = (scan_reg < ecount_reg) && !hit;
    assign hit        = v2_reg
                        && (b2_reg <= END_W'(query_reg))
                        && ((ALN_W'(b2_reg) + ALN_W'(l2_reg)) > ALN_W'(query_reg));
    assign scan_empty = !(scan_reg < ecount_reg) && !v1_reg && !v2_reg;

    assign align_mask = (ALN_W'(1) << align_reg) - ALN_W'(1);
    assign aligned    = (ALN_W'(end_reg) + align_mask) & ~align_mask;

    assign mem_we     = (state_reg == S_COMMIT);
    assign mem_wdata  = '{offset: off_reg, length: size_reg};

    // APB read
    always_comb
    begin
        unique case (paddr[4:3])
            REG_BASE:    prdata = PDATA_W'(base_reg);
            REG_RESERVE: prdata = PDATA_W'(reserve_reg);
            REG_ALIGN:   prdata = PDATA_W'(align_reg);
            default:     prdata = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_LOOKUP)
                        state_next = S_SCAN;
                    else if (table_full)
                        state_next = S_RESULT;
                    else
                        state_next = S_GROW;
                end
            end
            S_GROW:
            begin
                if (!grow_need)
                    state_next = S_COMMIT;
                else if (!grow_room)
                    state_next = S_RESULT;
            end
            S_COMMIT:
                state_next = S_RESULT;
            S_SCAN:
            begin
                if (hit || scan_empty)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        off_next         = off_reg;
        dcount_next      = dcount_reg;
        ecount_next      = ecount_reg;
        d_next           = d_reg;
        steps_next       = steps_reg;
        scan_next        = scan_reg;
        end_next         = end_reg;
        r_next           = r_reg;
        size_next        = size_reg;
        query_next       = query_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        res_base_next    = res_base_reg;
        res_len_next     = res_len_reg;
        res_steps_next   = res_steps_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_base_next    = out_base_reg;
        out_len_next     = out_len_reg;
        out_steps_next   = out_steps_reg;
        out_reserve_next = out_reserve_reg;

        v1_next = (state_reg == S_SCAN) && issue;
        v2_next = (state_reg == S_SCAN) && v1_reg && !hit;
        b2_next = END_W'(base_reg) + END_W'(rd_reg.offset);
        l2_next = rd_reg.length;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    size_next  = request_size;
                    query_next = query_address;
                    end_next   = END_W'(off_reg) + END_W'(request_size);
                    d_next     = dcount_reg;
                    steps_next = '0;
                    r_next     = OFF_W'(reserve_reg) << dcount_reg;
                    scan_next  = '0;
                    if (action == ACT_ALLOC && table_full)
                    begin
                        res_status_next = STAT_FULL;
                        res_addr_next   = '0;
                        res_base_next   = '0;
                        res_len_next    = '0;
                        res_steps_next  = '0;
                    end
                end
            end
            S_GROW:
            begin
                if (grow_need && grow_room)
                begin
                    d_next     = d_reg + DBL_W'(1);
                    steps_next = steps_reg + DBL_W'(1);
                    r_next     = r_reg << 1;
                end
                else if (grow_need)
                begin
                    // cap reached: no state changes, not even the doubling count
                    res_status_next = STAT_CAP;
                    res_addr_next   = '0;
                    res_base_next   = '0;
                    res_len_next    = '0;
                    res_steps_next  = '0;
                end
            end
            S_COMMIT:
            begin
                dcount_next     = d_reg;
                ecount_next     = ecount_reg + CNT_W'(1);
                off_next        = aligned[OFF_W-1:0];
                res_status_next = STAT_OK;
                res_addr_next   = OFF_W'(END_W'(base_reg) + END_W'(off_reg));
                res_base_next   = '0;
                res_len_next    = '0;
                res_steps_next  = steps_reg;
            end
            S_SCAN:
            begin
                if (issue)
                    scan_next = scan_reg + CNT_W'(1);
                if (hit)
                begin
                    res_status_next = STAT_OK;
                    res_addr_next   = '0;
                    res_base_next   = b2_reg[OFF_W-1:0];
                    res_len_next    = l2_reg;
                    res_steps_next  = '0;
                end
                else if (scan_empty)
                begin
                    res_status_next = STAT_MISS;
                    res_addr_next   = '0;
                    res_base_next   = '0;
                    res_len_next    = '0;
                    res_steps_next  = '0;
                end
            end
            S_RESULT:
            begin
                // hold until the output register frees
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_addr_next    = res_addr_reg;
                    out_base_next    = res_base_reg;
                    out_len_next     = res_len_reg;
                    out_steps_next   = res_steps_reg;
                    out_reserve_next = OFF_W'(reserve_reg) << dcount_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RST;
            reserve_reg   <= RESERVE_RST;
            align_reg     <= ALIGN_RST;
            state_reg     <= S_IDLE;
            off_reg       <= '0;
            dcount_reg    <= '0;
            ecount_reg    <= '0;
            d_reg         <= '0;
            steps_reg     <= '0;
            scan_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (paddr[4:3])
                    REG_BASE:    base_reg    <= pwdata[ADDR_W-1:0];
                    REG_RESERVE: reserve_reg <= pwdata[SIZE_W-1:0];
                    REG_ALIGN:   align_reg   <= pwdata[LOG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            off_reg       <= off_next;
            dcount_reg    <= dcount_next;
            ecount_reg    <= ecount_next;
            d_reg         <= d_next;
            steps_reg     <= steps_next;
            scan_reg      <= scan_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg         <= end_next;
        r_reg           <= r_next;
        size_reg        <= size_next;
        query_reg       <= query_next;
        b2_reg          <= b2_next;
        l2_reg          <= l2_next;
        res_status_reg  <= res_status_next;
        res_addr_reg    <= res_addr_next;
        res_base_reg    <= res_base_next;
        res_len_reg     <= res_len_next;
        res_steps_reg   <= res_steps_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
        out_base_reg    <= out_base_next;
        out_len_reg     <= out_len_next;
        out_steps_reg   <= out_steps_next;
        out_reserve_reg <= out_reserve_next;
    end

    // Region table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[ecount_reg[IDX_W-1:0]] <= mem_wdata;
        rd_reg <= table_mem[scan_reg[IDX_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign alloc_address = out_addr_reg;
    assign found_base    = out_base_reg;
    assign found_length  = out_len_reg;
    assign grow_steps    = out_steps_reg;
    assign reserve_size  = out_reserve_reg;

endmodule
